>>> rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty when synthesizing.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every rising edge of clk, off while rst is high.
`define GFFC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define GFFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GFFC_ASSERT(lbl, clk, rst, prop, msg)
`define GFFC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/core/gffc_pkg.sv
// -----------------------------------------------------------------------------
// Flood fill connectivity package
// Widths, register codes and the sequencer program of the fill unit.
// -----------------------------------------------------------------------------
package gffc_pkg;

  localparam int GRID_MAX_SIDE = 16;
  localparam int CELLS         = GRID_MAX_SIDE * GRID_MAX_SIDE;
  localparam int SIDE_W        = $clog2(GRID_MAX_SIDE);
  localparam int IDX_W         = 2 * SIDE_W;
  localparam int MEM_DEPTH     = 1 << IDX_W;
  localparam int PTR_W         = $clog2(MEM_DEPTH + 1);
  localparam int DIM_W         = $clog2(GRID_MAX_SIDE + 1);
  localparam int AREA_W        = 2 * DIM_W;
  localparam int CNT_W         = $clog2(CELLS + 1);

  localparam int COORD_W   = 4;
  localparam int SIZE_W    = 5;
  localparam int OUT_CNT_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST  = 5'd10;
  localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST = 5'd10;
  localparam logic [COORD_W-1:0] START_X_RST     = 4'd5;
  localparam logic [COORD_W-1:0] START_Y_RST     = 4'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_START_X     = 2'd2,
    REG_START_Y     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_RIGHT,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  typedef enum logic [3:0] {
    STEP_CLEAR,
    STEP_IDLE,
    STEP_WRITE,
    STEP_INIT,
    STEP_SEED,
    STEP_POP,
    STEP_NREAD,
    STEP_NTEST,
    STEP_SWEEP_RD,
    STEP_SWEEP_WR,
    STEP_EMIT
  } step_t;

  typedef enum logic [3:0] {
    OP_CLEAR,
    OP_ACCEPT,
    OP_WRITE,
    OP_INIT,
    OP_SEED,
    OP_POP,
    OP_NREAD,
    OP_NTEST,
    OP_SWEEP_RD,
    OP_SWEEP_WR,
    OP_EMIT
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_CLR_BUSY,
    C_NO_ACCEPT,
    C_NO_CHECK,
    C_START_OUT,
    C_QUEUE_EMPTY,
    C_DIR_MORE,
    C_OUT_BUSY
  } cond_t;

  // One control word: the branch target is taken when cond holds, else seq.
  typedef struct packed {
    logic  in_rdy;
    uop_t  op;
    cond_t cond;
    step_t br;
    step_t seq;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      STEP_CLEAR:    w = '{1'b0, OP_CLEAR,    C_CLR_BUSY,    STEP_CLEAR,    STEP_IDLE};
      STEP_IDLE:     w = '{1'b1, OP_ACCEPT,   C_NO_ACCEPT,   STEP_IDLE,     STEP_WRITE};
      STEP_WRITE:    w = '{1'b0, OP_WRITE,    C_NO_CHECK,    STEP_IDLE,     STEP_INIT};
      STEP_INIT:     w = '{1'b0, OP_INIT,     C_START_OUT,   STEP_EMIT,     STEP_SEED};
      STEP_SEED:     w = '{1'b0, OP_SEED,     C_NEVER,       STEP_POP,      STEP_POP};
      STEP_POP:      w = '{1'b0, OP_POP,      C_QUEUE_EMPTY, STEP_SWEEP_RD, STEP_NREAD};
      STEP_NREAD:    w = '{1'b0, OP_NREAD,    C_NEVER,       STEP_NTEST,    STEP_NTEST};
      STEP_NTEST:    w = '{1'b0, OP_NTEST,    C_DIR_MORE,    STEP_NREAD,    STEP_POP};
      STEP_SWEEP_RD: w = '{1'b0, OP_SWEEP_RD, C_NEVER,       STEP_SWEEP_WR, STEP_SWEEP_WR};
      STEP_SWEEP_WR: w = '{1'b0, OP_SWEEP_WR, C_QUEUE_EMPTY, STEP_EMIT,     STEP_SWEEP_RD};
      STEP_EMIT:     w = '{1'b0, OP_EMIT,     C_OUT_BUSY,    STEP_EMIT,     STEP_IDLE};
      default:       w = '{1'b0, OP_EMIT,     C_NEVER,       STEP_IDLE,     STEP_IDLE};
    endcase
    return w;
  endfunction

  // Out-of-range sizes are pulled into one to GRID_MAX_SIDE.
  function automatic logic [DIM_W-1:0] clamp_side(logic [SIZE_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > GRID_MAX_SIDE) begin
      r = DIM_W'(GRID_MAX_SIDE);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

>>> rtl/core/gffc_cell_if.sv
// -----------------------------------------------------------------------------
// Cell write channel
// Valid/ready channel carrying one cell write word and its check flag.
// -----------------------------------------------------------------------------
interface gffc_cell_if;
  import gffc_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] cell_x;
  logic [COORD_W-1:0] cell_y;
  logic               blocked;
  logic               check_now;

  modport source (output valid, output cell_x, output cell_y, output blocked,
                  output check_now, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input blocked,
                  input check_now, output ready);
endinterface

>>> rtl/core/gffc_result_if.sv
// -----------------------------------------------------------------------------
// Connectivity result channel
// Valid/ready channel carrying one fill result word.
// -----------------------------------------------------------------------------
interface gffc_result_if;
  import gffc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 accessible;
  logic [OUT_CNT_W-1:0] reached_count;
  logic [OUT_CNT_W-1:0] free_count;

  modport source (output valid, output accessible, output reached_count,
                  output free_count, input ready);
  modport sink   (input valid, input accessible, input reached_count,
                  input free_count, output ready);
endinterface

>>> rtl/core/grid_flood_fill_connectivity_unit.sv
// -----------------------------------------------------------------------------
// Grid flood fill connectivity unit
// Stores a grid of blocked marks and runs a 4-connected breadth-first fill
// from the start cell on request, reporting reached and free cell counts.
// -----------------------------------------------------------------------------
// A plain cell write is accepted, then read-modify-writes the map. A checked
// write then runs the fill and gives its result word, or goes straight to the
// result when the start cell lies outside the area; each reached cell costs a
// queue pop, a map read and test per neighbor, and a read and write to wipe its
// mark. After reset a clearing pass sweeps both maps before the first word is
// taken; configuration writes are taken throughout.
module grid_flood_fill_connectivity_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wen,
  input  logic [gffc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gffc_pkg::CFG_DAT_W-1:0] cfg_data,
  gffc_cell_if.sink                 cells,
  gffc_result_if.source             results
);
  import gffc_pkg::*;

  `include "assert_macros.svh"

  logic [SIZE_W-1:0]  grid_width;
  logic [SIZE_W-1:0]  grid_height;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;

  step_t  pc;
  step_t  pc_next;
  ucode_t uw;
  logic   cond_true;

  logic [IDX_W-1:0] clr_cnt;
  logic [CNT_W-1:0] blocked_total;
  logic [CNT_W-1:0] reach_count;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  dir_t             dir;

  logic             item_inside;
  logic             item_blocked;
  logic             item_check;
  logic [IDX_W-1:0] item_addr;

  logic             blocked_mem [MEM_DEPTH];
  logic             b_rd;
  logic             b_we;
  logic             b_re;
  logic             b_wdata;
  logic [IDX_W-1:0] b_waddr;
  logic [IDX_W-1:0] b_raddr;

  logic [IDX_W-1:0] q_mem [MEM_DEPTH];
  logic [IDX_W-1:0] q_rd;
  logic             q_we;
  logic             q_re;
  logic [IDX_W-1:0] q_wdata;

  logic             visited_mem [MEM_DEPTH];
  logic             v_rd;
  logic             v_we;
  logic             v_wdata;
  logic [IDX_W-1:0] v_waddr;

  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [AREA_W-1:0] area;
  logic [AREA_W-1:0] free_wide;
  logic [CNT_W-1:0]  free_cells;
  logic              start_ok;
  logic [IDX_W-1:0]  start_addr;
  logic              accept;
  logic [IDX_W-1:0]  in_addr;
  logic              in_inside;

  logic [SIDE_W-1:0] cx;
  logic [SIDE_W-1:0] cy;
  logic [SIDE_W-1:0] nx;
  logic [SIDE_W-1:0] ny;
  logic              nb_ok;
  logic [IDX_W-1:0]  n_addr;
  logic              n_ok;
  logic              push;

  logic                 out_valid;
  logic                 out_acc;
  logic [OUT_CNT_W-1:0] out_reached;
  logic [OUT_CNT_W-1:0] out_free;
  logic                 emit_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_WIDTH_RST;
      grid_height <= GRID_HEIGHT_RST;
      start_x     <= START_X_RST;
      start_y     <= START_Y_RST;
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        REG_START_X:     start_x     <= cfg_data[COORD_W-1:0];
        REG_START_Y:     start_y     <= cfg_data[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w          = clamp_side(grid_width);
    h          = clamp_side(grid_height);
    area       = AREA_W'(w) * AREA_W'(h);
    free_wide  = (area > AREA_W'(blocked_total)) ? area - AREA_W'(blocked_total) : '0;
    free_cells = CNT_W'(free_wide);
    start_ok   = (32'(start_x) < 32'(w)) && (32'(start_y) < 32'(h));
    start_addr = {SIDE_W'(start_y), SIDE_W'(start_x)};
    in_addr    = {SIDE_W'(cells.cell_y), SIDE_W'(cells.cell_x)};
    in_inside  = (32'(cells.cell_x) < GRID_MAX_SIDE) && (32'(cells.cell_y) < GRID_MAX_SIDE);
  end

  // Sequencer.
  assign uw          = ucode_rom(pc);
  assign cells.ready = uw.in_rdy;
  assign accept      = cells.valid && uw.in_rdy;
  assign emit_load   = (uw.op == OP_EMIT) && !(out_valid && !results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    case (uw.cond)
      C_NEVER:       cond_true = 1'b0;
      C_CLR_BUSY:    cond_true = clr_cnt != '1;
      C_NO_ACCEPT:   cond_true = !accept;
      C_NO_CHECK:    cond_true = !item_check;
      C_START_OUT:   cond_true = !start_ok;
      C_QUEUE_EMPTY: cond_true = head == tail;
      C_DIR_MORE:    cond_true = dir != DIR_DOWN;
      C_OUT_BUSY:    cond_true = out_valid && !results.ready;
      default:       cond_true = 1'b0;
    endcase
    pc_next = cond_true ? uw.br : uw.seq;
  end

  // Neighbor of the cell at the queue head for the current direction.
  always_comb begin
    cx = q_rd[SIDE_W-1:0];
    cy = q_rd[IDX_W-1:SIDE_W];
    nx = cx;
    ny = cy;
    case (dir)
      DIR_LEFT: begin
        nb_ok = cx != '0;
        nx    = cx - SIDE_W'(1);
      end
      DIR_RIGHT: begin
        nb_ok = (32'(cx) + 32'd1) < 32'(w);
        nx    = cx + SIDE_W'(1);
      end
      DIR_UP: begin
        nb_ok = cy != '0;
        ny    = cy - SIDE_W'(1);
      end
      DIR_DOWN: begin
        nb_ok = (32'(cy) + 32'd1) < 32'(h);
        ny    = cy + SIDE_W'(1);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  assign push = (uw.op == OP_NTEST) && n_ok && !v_rd && !b_rd;

  always_comb begin
    b_we    = 1'b0;
    b_wdata = 1'b0;
    b_waddr = item_addr;
    b_re    = 1'b0;
    b_raddr = in_addr;
    q_we    = 1'b0;
    q_wdata = n_addr;
    q_re    = 1'b0;
    v_we    = 1'b0;
    v_wdata = 1'b0;
    v_waddr = n_addr;
    case (uw.op)
      OP_CLEAR: begin
        b_we    = 1'b1;
        b_waddr = clr_cnt;
        v_we    = 1'b1;
        v_waddr = clr_cnt;
      end
      OP_ACCEPT: b_re = accept;
      OP_WRITE: begin
        b_we    = item_inside && (b_rd != item_blocked);
        b_wdata = item_blocked;
      end
      OP_SEED: begin
        q_we    = 1'b1;
        q_wdata = start_addr;
        v_we    = 1'b1;
        v_wdata = 1'b1;
        v_waddr = start_addr;
      end
      OP_POP:   q_re = head != tail;
      OP_NREAD: begin
        b_re    = 1'b1;
        b_raddr = {ny, nx};
      end
      OP_NTEST: begin
        q_we    = push && (tail < PTR_W'(MEM_DEPTH));
        v_we    = push;
        v_wdata = 1'b1;
      end
      OP_SWEEP_RD: q_re = 1'b1;
      OP_SWEEP_WR: begin
        v_we    = 1'b1;
        v_waddr = q_rd;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      blocked_mem[b_waddr] <= b_wdata;
    end
    if (b_re) begin
      b_rd <= blocked_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail[IDX_W-1:0]] <= q_wdata;
    end
    if (q_re) begin
      q_rd <= q_mem[head[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (v_we) begin
      visited_mem[v_waddr] <= v_wdata;
    end
    if (uw.op == OP_NREAD) begin
      v_rd <= visited_mem[b_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_addr    <= in_addr;
      item_inside  <= in_inside;
      item_blocked <= cells.blocked;
      item_check   <= cells.check_now;
    end
    if (uw.op == OP_NREAD) begin
      n_addr <= {ny, nx};
      n_ok   <= nb_ok;
    end
    if (emit_load) begin
      out_acc     <= reach_count == free_cells;
      out_reached <= OUT_CNT_W'(reach_count);
      out_free    <= OUT_CNT_W'(free_cells);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt       <= '0;
      blocked_total <= '0;
      reach_count   <= '0;
      head          <= '0;
      tail          <= '0;
      dir           <= DIR_LEFT;
    end else begin
      case (uw.op)
        OP_CLEAR: clr_cnt <= clr_cnt + IDX_W'(1);
        OP_WRITE: begin
          if (b_we) begin
            if (item_blocked) begin
              blocked_total <= blocked_total + CNT_W'(1);
            end else if (blocked_total != '0) begin
              blocked_total <= blocked_total - CNT_W'(1);
            end
          end
        end
        OP_INIT: begin
          head        <= '0;
          tail        <= '0;
          reach_count <= '0;
        end
        OP_SEED: begin
          tail        <= PTR_W'(1);
          reach_count <= CNT_W'(1);
        end
        OP_POP: begin
          dir <= DIR_LEFT;
          if (head != tail) begin
            head <= head + PTR_W'(1);
          end else begin
            head <= '0;
          end
        end
        OP_NTEST: begin
          dir <= dir_t'(dir + 2'd1);
          if (push) begin
            reach_count <= reach_count + CNT_W'(1);
            if (tail < PTR_W'(MEM_DEPTH)) begin
              tail <= tail + PTR_W'(1);
            end
          end
        end
        OP_SWEEP_RD: head <= head + PTR_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid         = out_valid;
  assign results.accessible    = out_acc;
  assign results.reached_count = out_reached;
  assign results.free_count    = out_free;

  `GFFC_ASSERT(a_head_le_tail, clk, rst, head <= tail, "Queue head passed its tail.")
  `GFFC_ASSERT(a_count_tail, clk, rst, 32'(reach_count) == 32'(tail), "Count and tail differ.")
  `GFFC_ASSERT(a_map_wr, clk, rst, b_we |-> (pc == STEP_CLEAR || pc == STEP_WRITE), "Stray map write.")
  `GFFC_ASSERT(a_accept_write, clk, rst, accept |=> (pc == STEP_WRITE), "Accept without write.")

endmodule

>>> test/gffc_fill_checker.sv
// -----------------------------------------------------------------------------
// Flood fill connectivity checker
// Watches the configuration port and both channels of the fill unit. It keeps
// its own copy of the obstacle grid and registers, predicts each fill result
// word with a breadth-first search, and compares every accepted result word
// against the oldest prediction.
// -----------------------------------------------------------------------------
module gffc_fill_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [gffc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gffc_pkg::CFG_DAT_W-1:0] cfg_data,
  gffc_cell_if                           cells,
  gffc_result_if                         results,
  output int                             pending,
  output int                             failures
);
  import gffc_pkg::*;

  localparam int EXP_DEPTH = 16;

  typedef struct packed {
    logic                 accessible;
    logic [OUT_CNT_W-1:0] reached;
    logic [OUT_CNT_W-1:0] free_cells;
  } fill_result_t;

  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;
  logic [COORD_W-1:0] sx_reg;
  logic [COORD_W-1:0] sy_reg;
  bit                 obstacle [CELLS];
  int                 obstacle_total;
  fill_result_t       expected_fills [EXP_DEPTH];
  int                 exp_wr = 0;
  int                 exp_rd = 0;
  int                 fail_count = 0;

  assign failures = fail_count;

  task automatic report_mismatch(string msg);
    $display("%0t fill check: %s", $time, msg);
    fail_count++;
  endtask

  function automatic int side_used(logic [SIZE_W-1:0] v);
    int r;
    r = int'(v);
    if (r < 1) r = 1;
    if (r > GRID_MAX_SIDE) r = GRID_MAX_SIDE;
    return r;
  endfunction

  // Breadth-first fill from the start cell; the start cell counts whenever it lies inside the area.
  function automatic fill_result_t flood_result();
    fill_result_t r;
    bit           seen [CELLS];
    int           frontier [CELLS];
    int           f_head, f_tail;
    int           w, h, cur, cx, cy, nx, ny, d, n, reach, area, free_cells;
    w = side_used(width_reg);
    h = side_used(height_reg);
    foreach (seen[i]) seen[i] = 1'b0;
    reach = 0;
    f_head = 0;
    f_tail = 0;
    if (int'(sx_reg) < w && int'(sy_reg) < h) begin
      cur = int'(sy_reg) * GRID_MAX_SIDE + int'(sx_reg);
      seen[cur] = 1'b1;
      frontier[f_tail] = cur;
      f_tail++;
      reach = 1;
      while (f_head < f_tail) begin
        cur = frontier[f_head];
        f_head++;
        cx = cur % GRID_MAX_SIDE;
        cy = cur / GRID_MAX_SIDE;
        for (d = 0; d < 4; d++) begin
          nx = cx;
          ny = cy;
          case (dir_t'(d))
            DIR_LEFT:  nx = cx - 1;
            DIR_RIGHT: nx = cx + 1;
            DIR_UP:    ny = cy - 1;
            default:   ny = cy + 1;
          endcase
          if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
            n = ny * GRID_MAX_SIDE + nx;
            if (!seen[n] && !obstacle[n]) begin
              seen[n] = 1'b1;
              frontier[f_tail] = n;
              f_tail++;
              reach++;
            end
          end
        end
      end
    end
    area = w * h;
    free_cells = (area > obstacle_total) ? area - obstacle_total : 0;
    r.accessible = (reach == free_cells);
    r.reached    = OUT_CNT_W'(reach);
    r.free_cells = OUT_CNT_W'(free_cells);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    fill_result_t want;
    int           idx;
    if (rst) begin
      width_reg  = GRID_WIDTH_RST;
      height_reg = GRID_HEIGHT_RST;
      sx_reg     = START_X_RST;
      sy_reg     = START_Y_RST;
      foreach (obstacle[i]) obstacle[i] = 1'b0;
      obstacle_total = 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_reg_t'(cfg_index))
          REG_GRID_WIDTH:  width_reg  = cfg_data;
          REG_GRID_HEIGHT: height_reg = cfg_data;
          REG_START_X:     sx_reg     = cfg_data[COORD_W-1:0];
          default:         sy_reg     = cfg_data[COORD_W-1:0];
        endcase
      end
      if (cells.valid && cells.ready) begin
        idx = int'(cells.cell_y) * GRID_MAX_SIDE + int'(cells.cell_x);
        if (obstacle[idx] != cells.blocked) begin
          if (cells.blocked) obstacle_total++;
          else if (obstacle_total > 0) obstacle_total--;
          obstacle[idx] = cells.blocked;
        end
        if (cells.check_now) begin
          if (exp_wr - exp_rd >= EXP_DEPTH) begin
            report_mismatch("too many checks outstanding");
          end else begin
            expected_fills[exp_wr % EXP_DEPTH] = flood_result();
            exp_wr++;
          end
        end
      end
      if (results.valid && results.ready) begin
        if (exp_wr == exp_rd) begin
          report_mismatch("result word arrived with no check outstanding");
        end else begin
          want = expected_fills[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (results.accessible !== want.accessible ||
              results.reached_count !== want.reached ||
              results.free_count !== want.free_cells) begin
            report_mismatch($sformatf(
              "accessible %b/%b reached %0d/%0d free %0d/%0d (got/expected)",
              results.accessible, want.accessible, results.reached_count,
              want.reached, results.free_count, want.free_cells));
          end
        end
      end
    end
    pending = exp_wr - exp_rd;
  end

endmodule

>>> test/grid_flood_fill_connectivity_unit_tb.sv
// -----------------------------------------------------------------------------
// Flood fill connectivity unit testbench
// Drives cell write words and configuration writes into the fill unit, with
// directed corner cases first and then randomized phases over several grid
// sizes and start cells, under varying sender and receiver idling. A checker
// beside the block predicts and compares every result word.
// -----------------------------------------------------------------------------
module grid_flood_fill_connectivity_unit_tb;
  import gffc_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 104;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  logic                 hold_req;
  int                   pending;
  int                   failures;
  int                   quiet_cycles = 0;
  int                   area_w = 10;
  int                   area_h = 10;

  int phase_w  [PHASES] = '{4, 16, 1, 16, 31, 6, 8, 3, 17, 5, 0, 7};
  int phase_h  [PHASES] = '{4, 16, 16, 1, 0, 5, 8, 7, 17, 9, 0, 7};
  int phase_sx [PHASES] = '{0, 15, 0, 8, 3, 3, 7, 5, 0, 2, 0, 3};
  int phase_sy [PHASES] = '{0, 15, 7, 0, 0, 2, 7, 1, 15, 4, 0, 3};

  gffc_cell_if   cells ();
  gffc_result_if results ();

  grid_flood_fill_connectivity_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells),
    .results   (results)
  );

  gffc_fill_checker u_fill_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cells     (cells),
    .results   (results),
    .pending   (pending),
    .failures  (failures)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (cells.valid && cells.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("grid_flood_fill_connectivity_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The result side stalls at random, and once holds off for a long stretch.
  initial begin : receiver
    bit hold_done;
    int i;
    hold_done = 1'b0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        results.ready <= 1'b0;
        for (i = 0; i < HOLD_CYCLES; i++) @(posedge clk);
        hold_done = 1'b1;
      end
      results.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                           logic blocked, logic check_now);
    cells.valid     <= 1'b1;
    cells.cell_x    <= x;
    cells.cell_y    <= y;
    cells.blocked   <= blocked;
    cells.check_now <= check_now;
    do @(posedge clk); while (!cells.ready);
    while ($urandom_range(99) < idle_pct) begin
      cells.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Waits until every check has reported and the last plain write has settled.
  task automatic drain_block();
    cells.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(int w, int h, int sx, int sy);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= CFG_DAT_W'(w);
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= CFG_DAT_W'(h);
    @(posedge clk);
    cfg_index <= REG_START_X;
    cfg_data  <= CFG_DAT_W'(sx);
    @(posedge clk);
    cfg_index <= REG_START_Y;
    cfg_data  <= CFG_DAT_W'(sy);
    @(posedge clk);
    cfg_wen <= 1'b0;
    area_w = (w < 1) ? 1 : ((w > GRID_MAX_SIDE) ? GRID_MAX_SIDE : w);
    area_h = (h < 1) ? 1 : ((h > GRID_MAX_SIDE) ? GRID_MAX_SIDE : h);
  endtask

  initial begin : stimulus
    int p, n, k, kind, len, hole, line_at;
    bit across;
    cells.valid     <= 1'b0;
    cells.cell_x    <= '0;
    cells.cell_y    <= '0;
    cells.blocked   <= 1'b0;
    cells.check_now <= 1'b0;
    cfg_wen         <= 1'b0;
    cfg_index       <= REG_GRID_WIDTH;
    cfg_data        <= '0;
    hold_req        <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Open grid, then a blocked start cell, then a wall that cuts off the left.
    send_word(4'd0, 4'd0, 1'b0, 1'b1);
    send_word(4'd5, 4'd5, 1'b1, 1'b1);
    send_word(4'd5, 4'd5, 1'b0, 1'b0);
    for (k = 0; k < 10; k++) send_word(4'd3, 4'(k), 1'b1, k == 9);
    // Obstacles outside the area still reduce the free count.
    send_word(4'd15, 4'd15, 1'b1, 1'b1);
    send_word(4'd15, 4'd0, 1'b1, 1'b0);
    send_word(4'd0, 4'd15, 1'b1, 1'b1);
    drain_block();
    // A zero size is taken as one, so the free count saturates at zero.
    set_config(0, 0, 0, 0);
    send_word(4'd0, 4'd0, 1'b0, 1'b1);
    drain_block();
    // Start cell outside the area reaches nothing.
    set_config(3, 3, 15, 15);
    send_word(4'd1, 4'd1, 1'b0, 1'b1);
    drain_block();
    set_config(31, 17, 0, 0);
    send_word(4'd3, 4'd0, 1'b0, 1'b1);
    send_word(4'd0, 4'd0, 1'b1, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      drain_block();
      set_config(phase_w[p], phase_h[p], phase_sx[p], phase_sy[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 82; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 82; end
        default: begin idle_pct = 34; stall_pct <= 34; end
      endcase
      if (p == 4) hold_req <= 1'b1;
      n = 0;
      while (n < PHASE_ITEMS) begin
        kind = $urandom_range(99);
        if (kind < 10) begin
          // A wall across the area, sometimes with one gap, then a check.
          across = 1'($urandom_range(1));
          len = across ? area_w : area_h;
          line_at = across ? $urandom_range(area_h - 1) : $urandom_range(area_w - 1);
          hole = $urandom_range(len);
          for (k = 0; k < len; k++) begin
            if (across) send_word(4'(k), 4'(line_at), k != hole, k == len - 1);
            else send_word(4'(line_at), 4'(k), k != hole, k == len - 1);
          end
          n += len;
        end else if (kind < 25) begin
          send_word(4'($urandom_range(15)), 4'($urandom_range(15)),
                    1'($urandom_range(1)), $urandom_range(3) == 0);
          n++;
        end else begin
          send_word(4'($urandom_range(area_w - 1)), 4'($urandom_range(area_h - 1)),
                    $urandom_range(99) < 35, $urandom_range(99) < 15);
          n++;
        end
      end
    end

    idle_pct = 0;
    stall_pct <= 0;
    drain_block();
    if (failures == 0) begin
      $display("grid_flood_fill_connectivity_unit regression: pass");
    end else begin
      $display("grid_flood_fill_connectivity_unit regression: fail");
    end
    $finish;
  end

endmodule
